// ===== rtl/balance_robot_cascade_control_macros.svh =====
// assertion macros for the balance robot cascade controller
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef BALANCE_ROBOT_CASCADE_CONTROL_MACROS_SVH
`define BALANCE_ROBOT_CASCADE_CONTROL_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BRCC_ASSERT_IMM(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define BRCC_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define BRCC_ASSERT_IMM(lbl, pre, post, msg)
`define BRCC_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/brcc_pkg.sv =====
// shared widths, constants, control word types and microcode rom
// for the balance robot cascade controller; no dependencies
package brcc_pkg;

  // field widths
  localparam int CountW   = 16;
  localparam int PitchW   = 17;
  localparam int RateW    = 16;
  localparam int CmdW     = 8;
  localparam int GainW    = 32;
  localparam int LimitW   = 15;
  localparam int DriveW   = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // internal widths
  localparam int ErrW     = 18;
  localparam int IntW     = 15;
  localparam int IntSumW  = 19;
  localparam int NumW     = 22;
  localparam int SpeedW   = 5;
  localparam int TurnW    = 8;
  localparam int VelW     = 30;
  localparam int AngW     = 32;
  localparam int DiffW    = 39;
  localparam int AccW     = 64;
  localparam int AOutW    = 36;
  localparam int YawW     = 29;
  localparam int SumW     = 37;
  localparam int UpcW     = 4;

  // constants
  localparam int INTEGRAL_BOUND = 10000;
  localparam int SpeedMax       = 15;
  localparam int TurnMax        = 80;
  localparam int Div10Magic     = 1677722;  // ceil(2^24 / 10)
  localparam int Div10Shift     = 24;
  localparam int VelShift       = 20;
  localparam int AngShift       = 28;
  localparam int YawShift       = 20;
  localparam int AngMax         = 2147483647;

  localparam logic signed [CmdW-1:0]    SpeedLim = CmdW'(SpeedMax);
  localparam logic signed [CmdW-1:0]    TurnLim  = CmdW'(TurnMax);
  localparam logic signed [IntSumW-1:0] IntLim   = IntSumW'(INTEGRAL_BOUND);
  localparam logic signed [DiffW-1:0]   DiffLim  = DiffW'(AngMax);

  // register reset values
  localparam logic signed [PitchW-1:0] BalanceAngleRst = '0;
  localparam logic signed [GainW-1:0]  AngleKpRst      = GainW'(262144000);
  localparam logic signed [GainW-1:0]  AngleKdRst      = GainW'(629146);
  localparam logic signed [GainW-1:0]  SpeedKpRst      = GainW'(681574);
  localparam logic signed [GainW-1:0]  SpeedKiRst      = GainW'(3408);
  localparam logic signed [GainW-1:0]  YawKdRst        = GainW'(629146);
  localparam logic signed [GainW-1:0]  YawKpRst        = GainW'(20971520);
  localparam logic [LimitW-1:0]        DriveLimitRst   = LimitW'(7000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_BALANCE_ANGLE = 3'd0,
    REG_ANGLE_KP      = 3'd1,
    REG_ANGLE_KD      = 3'd2,
    REG_SPEED_KP      = 3'd3,
    REG_SPEED_KI      = 3'd4,
    REG_YAW_KD        = 3'd5,
    REG_YAW_KP        = 3'd6,
    REG_DRIVE_LIMIT   = 3'd7
  } cfg_reg_e;

  // multiplier operand pair
  typedef enum logic [2:0] {
    MS_DIV10,
    MS_SPEED_KP,
    MS_SPEED_KI,
    MS_ANGLE_KP,
    MS_ANGLE_KD,
    MS_YAW_KD,
    MS_YAW_KP
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_SH8
  } acc_op_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_NUM,
    OP_F,
    OP_INT,
    OP_V,
    OP_D,
    OP_Y,
    OP_A,
    OP_SUM,
    OP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_GOTO,
    JC_WAIT_IN,
    JC_WAIT_OUT
  } jmp_e;

  typedef struct packed {
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    dp_op_e           dp_op;
    jmp_e             jmp;
    logic [UpcW-1:0]  target;
  } ucode_t;

  localparam logic [UpcW-1:0] StepIdle = '0;

  function automatic ucode_t uc(mul_sel_e m, acc_op_e a, dp_op_e d, jmp_e j,
                                logic [UpcW-1:0] t);
    ucode_t w;
    w.mul_sel = m;
    w.acc_op  = a;
    w.dp_op   = d;
    w.jmp     = j;
    w.target  = t;
    return w;
  endfunction

  // control program; the product register lags the operand select by one step
  function automatic ucode_t ucode_rom(logic [UpcW-1:0] addr);
    ucode_t w;
    unique case (addr)
      4'd0:  w = uc(MS_DIV10,    ACC_HOLD,    OP_NOP, JC_WAIT_IN,  StepIdle);
      4'd1:  w = uc(MS_DIV10,    ACC_HOLD,    OP_NUM, JC_NEXT,     StepIdle);
      4'd2:  w = uc(MS_DIV10,    ACC_HOLD,    OP_NOP, JC_NEXT,     StepIdle);
      4'd3:  w = uc(MS_DIV10,    ACC_HOLD,    OP_F,   JC_NEXT,     StepIdle);
      4'd4:  w = uc(MS_SPEED_KP, ACC_HOLD,    OP_INT, JC_NEXT,     StepIdle);
      4'd5:  w = uc(MS_SPEED_KI, ACC_LOAD,    OP_NOP, JC_NEXT,     StepIdle);
      4'd6:  w = uc(MS_YAW_KD,   ACC_ADD,     OP_NOP, JC_NEXT,     StepIdle);
      4'd7:  w = uc(MS_YAW_KP,   ACC_LOAD,    OP_V,   JC_NEXT,     StepIdle);
      4'd8:  w = uc(MS_DIV10,    ACC_ADD,     OP_D,   JC_NEXT,     StepIdle);
      4'd9:  w = uc(MS_ANGLE_KP, ACC_HOLD,    OP_Y,   JC_NEXT,     StepIdle);
      4'd10: w = uc(MS_ANGLE_KD, ACC_LOAD,    OP_NOP, JC_NEXT,     StepIdle);
      4'd11: w = uc(MS_DIV10,    ACC_ADD_SH8, OP_NOP, JC_NEXT,     StepIdle);
      4'd12: w = uc(MS_DIV10,    ACC_HOLD,    OP_A,   JC_NEXT,     StepIdle);
      4'd13: w = uc(MS_DIV10,    ACC_HOLD,    OP_SUM, JC_NEXT,     StepIdle);
      4'd14: w = uc(MS_DIV10,    ACC_HOLD,    OP_OUT, JC_WAIT_OUT, StepIdle);
      4'd15: w = uc(MS_DIV10,    ACC_HOLD,    OP_NOP, JC_GOTO,     StepIdle);
    endcase
    return w;
  endfunction

  // arithmetic shift right that rounds toward zero
  function automatic logic signed [AccW-1:0] shr_trunc0(logic signed [AccW-1:0] x,
                                                        int unsigned sh);
    logic signed [AccW-1:0] bias;
    bias = x[AccW-1] ? ((AccW'(1) << sh) - AccW'(1)) : '0;
    return (x + bias) >>> sh;
  endfunction

endpackage

// ===== rtl/brcc_if.sv =====
// valid/ready channel interfaces for sensor items and drive results
// depends on brcc_pkg for field widths
interface brcc_in_if;
  import brcc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CountW-1:0] left_count;
  logic signed [CountW-1:0] right_count;
  logic signed [PitchW-1:0] pitch;
  logic signed [RateW-1:0]  pitch_rate;
  logic signed [RateW-1:0]  yaw_rate;
  logic signed [CmdW-1:0]   speed_command;
  logic signed [CmdW-1:0]   turn_command;
  logic                     clear_integral;

  modport source (
    output valid, left_count, right_count, pitch, pitch_rate, yaw_rate,
           speed_command, turn_command, clear_integral,
    input  ready
  );

  modport sink (
    input  valid, left_count, right_count, pitch, pitch_rate, yaw_rate,
           speed_command, turn_command, clear_integral,
    output ready
  );
endinterface

interface brcc_out_if;
  import brcc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] left_drive;
  logic signed [DriveW-1:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

// ===== rtl/balance_robot_cascade_control.sv =====
// balance robot cascade controller: microcoded sequencer around one 32x32 multiplier
// one transaction at a time: the next input is accepted only once the result is loaded
//   into the output register; the 15-step microprogram runs seven products through
//   the shared multiplier
// reset: rst_ni async active low; gains return to defaults, filter and integral clear
// depends on brcc_pkg, brcc_if.sv and balance_robot_cascade_control_macros.svh
`include "balance_robot_cascade_control_macros.svh"

module balance_robot_cascade_control (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [brcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [brcc_pkg::CfgDataW-1:0]  cfg_data_i,
  brcc_in_if.sink                        in_i,
  brcc_out_if.source                     out_o
);
  import brcc_pkg::*;

  // configuration registers
  logic signed [PitchW-1:0] balance_angle_q;
  logic signed [GainW-1:0]  angle_kp_q, angle_kd_q, speed_kp_q, speed_ki_q;
  logic signed [GainW-1:0]  yaw_kd_q, yaw_kp_q;
  logic [LimitW-1:0]        drive_limit_q;

  // sequencer
  logic [UpcW-1:0] upc_q, upc_d;
  ucode_t          cw;
  logic            in_acc, out_block, out_load;
  logic            out_valid_q, out_valid_d;

  // latched transaction
  logic signed [CountW-1:0] lc_q, rc_q;
  logic signed [PitchW-1:0] pitch_q;
  logic signed [RateW-1:0]  prate_q, yrate_q;
  logic signed [SpeedW-1:0] s_q;
  logic signed [TurnW-1:0]  t_q;
  logic                     clr_q;
  logic signed [SpeedW-1:0] s_sat;
  logic signed [TurnW-1:0]  t_sat;

  // loop state
  logic signed [ErrW-1:0]   fe_q, fe_d;
  logic signed [IntW-1:0]   si_q, si_d;

  // datapath registers
  logic signed [NumW-1:0]   num_q, num_d;
  logic [NumW-1:0]          num_abs;
  logic signed [ErrW-1:0]   err;
  logic signed [GainW-1:0]  mul_a, mul_b;
  logic signed [AccW-1:0]   p_q, p_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [VelW-1:0]   v_q, v_d;
  logic signed [AngW-1:0]   d_q, d_d;
  logic signed [DiffW-1:0]  d_full;
  logic signed [AOutW-1:0]  a_q, a_d;
  logic signed [YawW-1:0]   y_q, y_d;
  logic signed [SumW-1:0]   sl_q, sl_d, sr_q, sr_d;
  logic signed [IntSumW-1:0] int_sum;
  logic [ErrW-1:0]          quo;
  logic signed [SumW-1:0]   lim_s, ml, mr, mr_neg;
  logic signed [DriveW-1:0] left_q, right_q;

  // ---------------------------------------------------------------------------
  // configuration port, writes are expected only while the block is idle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      balance_angle_q <= BalanceAngleRst;
      angle_kp_q      <= AngleKpRst;
      angle_kd_q      <= AngleKdRst;
      speed_kp_q      <= SpeedKpRst;
      speed_ki_q      <= SpeedKiRst;
      yaw_kd_q        <= YawKdRst;
      yaw_kp_q        <= YawKpRst;
      drive_limit_q   <= DriveLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BALANCE_ANGLE: balance_angle_q <= cfg_data_i[PitchW-1:0];
        REG_ANGLE_KP:      angle_kp_q      <= cfg_data_i;
        REG_ANGLE_KD:      angle_kd_q      <= cfg_data_i;
        REG_SPEED_KP:      speed_kp_q      <= cfg_data_i;
        REG_SPEED_KI:      speed_ki_q      <= cfg_data_i;
        REG_YAW_KD:        yaw_kd_q        <= cfg_data_i;
        REG_YAW_KP:        yaw_kp_q        <= cfg_data_i;
        REG_DRIVE_LIMIT:   drive_limit_q   <= cfg_data_i[LimitW-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // microcode sequencer
  // ---------------------------------------------------------------------------
  assign cw        = ucode_rom(upc_q);
  assign in_i.ready = (cw.jmp == JC_WAIT_IN);
  assign in_acc    = in_i.valid && in_i.ready;
  // the output register parts the two sides; it only blocks the final step
  assign out_block = out_valid_q && !out_o.ready;
  assign out_load  = (cw.dp_op == OP_OUT) && !out_block;

  always_comb begin
    unique case (cw.jmp)
      JC_NEXT:     upc_d = upc_q + UpcW'(1);
      JC_GOTO:     upc_d = cw.target;
      JC_WAIT_IN:  upc_d = in_acc ? upc_q + UpcW'(1) : upc_q;
      JC_WAIT_OUT: upc_d = out_block ? upc_q : cw.target;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= StepIdle;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // input capture with command saturation
  // ---------------------------------------------------------------------------
  always_comb begin
    if (in_i.speed_command > SpeedLim) begin
      s_sat = SpeedW'(SpeedLim);
    end else if (in_i.speed_command < -SpeedLim) begin
      s_sat = SpeedW'(-SpeedLim);
    end else begin
      s_sat = in_i.speed_command[SpeedW-1:0];
    end
    if (in_i.turn_command > TurnLim) begin
      t_sat = TurnLim;
    end else if (in_i.turn_command < -TurnLim) begin
      t_sat = -TurnLim;
    end else begin
      t_sat = in_i.turn_command;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lc_q    <= in_i.left_count;
      rc_q    <= in_i.right_count;
      pitch_q <= in_i.pitch;
      prate_q <= in_i.pitch_rate;
      yrate_q <= in_i.yaw_rate;
      s_q     <= s_sat;
      t_q     <= t_sat;
      clr_q   <= in_i.clear_integral;
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier, product registered every cycle
  // ---------------------------------------------------------------------------
  assign num_abs = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

  always_comb begin
    unique case (cw.mul_sel)
      MS_DIV10: begin
        // divide by ten as a reciprocal multiply on the magnitude
        mul_a = GainW'(Div10Magic);
        mul_b = {{(GainW-NumW){1'b0}}, num_abs};
      end
      MS_SPEED_KP: begin
        mul_a = speed_kp_q;
        mul_b = GainW'(fe_q);
      end
      MS_SPEED_KI: begin
        mul_a = speed_ki_q;
        mul_b = GainW'(si_q);
      end
      MS_ANGLE_KP: begin
        mul_a = angle_kp_q;
        mul_b = d_q;
      end
      MS_ANGLE_KD: begin
        mul_a = angle_kd_q;
        mul_b = GainW'(prate_q);
      end
      MS_YAW_KD: begin
        mul_a = yaw_kd_q;
        mul_b = GainW'(yrate_q);
      end
      MS_YAW_KP: begin
        mul_a = yaw_kp_q;
        mul_b = GainW'(t_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_d = mul_a * mul_b;

  // accumulator over products; the pitch rate term carries an extra factor of 256
  always_comb begin
    unique case (cw.acc_op)
      ACC_HOLD:    acc_d = acc_q;
      ACC_LOAD:    acc_d = p_q;
      ACC_ADD:     acc_d = acc_q + p_q;
      ACC_ADD_SH8: acc_d = acc_q + (p_q <<< 8);
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath step results
  // ---------------------------------------------------------------------------
  // encoder-difference error and low-pass numerator 3*e + 7*f
  assign err   = ErrW'(rc_q) - ErrW'(lc_q) - ErrW'(s_q);
  assign num_d = (NumW'(err) <<< 1) + NumW'(err) + (NumW'(fe_q) <<< 3) - NumW'(fe_q);

  // quotient magnitude, sign restored from the numerator
  assign quo  = p_q[Div10Shift +: ErrW];
  assign fe_d = num_q[NumW-1] ? -$signed(quo) : $signed(quo);

  // clamped integral, clear applied after the clamp
  assign int_sum = IntSumW'(si_q) + IntSumW'(fe_q);
  always_comb begin
    if (clr_q) begin
      si_d = '0;
    end else if (int_sum > IntLim) begin
      si_d = IntW'(IntLim);
    end else if (int_sum < -IntLim) begin
      si_d = IntW'(-IntLim);
    end else begin
      si_d = int_sum[IntW-1:0];
    end
  end

  assign v_d = VelW'(shr_trunc0(acc_q, VelShift));
  assign y_d = YawW'(shr_trunc0(acc_q, YawShift));
  assign a_d = AOutW'(shr_trunc0(acc_q, AngShift));

  // angle error, velocity term in Q8.8, saturated to 32 bits before the product
  assign d_full = DiffW'(pitch_q) - DiffW'(balance_angle_q) - (DiffW'(v_q) <<< 8);
  always_comb begin
    if (d_full > DiffLim) begin
      d_d = AngW'(DiffLim);
    end else if (d_full < -DiffLim) begin
      d_d = AngW'(-DiffLim);
    end else begin
      d_d = d_full[AngW-1:0];
    end
  end

  // yaw term goes with the left motor and against the right
  assign sl_d = SumW'(a_q) + SumW'(v_q) + SumW'(y_q);
  assign sr_d = SumW'(a_q) + SumW'(v_q) - SumW'(y_q);

  // motor clamps, right side negated
  assign lim_s = $signed({{(SumW-LimitW){1'b0}}, drive_limit_q});
  always_comb begin
    if (sl_q > lim_s) begin
      ml = lim_s;
    end else if (sl_q < -lim_s) begin
      ml = -lim_s;
    end else begin
      ml = sl_q;
    end
    if (sr_q > lim_s) begin
      mr = lim_s;
    end else if (sr_q < -lim_s) begin
      mr = -lim_s;
    end else begin
      mr = sr_q;
    end
  end
  assign mr_neg = -mr;

  // loop state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q <= '0;
      si_q <= '0;
    end else begin
      if (cw.dp_op == OP_F) begin
        fe_q <= fe_d;
      end
      if (cw.dp_op == OP_INT) begin
        si_q <= si_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    acc_q <= acc_d;
    unique case (cw.dp_op)
      OP_NUM: num_q <= num_d;
      OP_V:   v_q   <= v_d;
      OP_D:   d_q   <= d_d;
      OP_Y:   y_q   <= y_d;
      OP_A:   a_q   <= a_d;
      OP_SUM: begin
        sl_q <= sl_d;
        sr_q <= sr_d;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      left_q  <= ml[DriveW-1:0];
      right_q <= mr_neg[DriveW-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_drive  = left_q;
  assign out_o.right_drive = right_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `BRCC_ASSERT_IMM(a_integral_bound, 1'b1,
                   (si_q <= IntW'(IntLim)) && (si_q >= IntW'(-IntLim)),
                   "speed integral out of bound")
  `BRCC_ASSERT_IMM(a_drive_limit, out_o.valid,
                   (SumW'(out_o.left_drive) <= lim_s) && (SumW'(out_o.left_drive) >= -lim_s) &&
                   (SumW'(out_o.right_drive) <= lim_s) && (SumW'(out_o.right_drive) >= -lim_s),
                   "drive beyond limit")
  `BRCC_ASSERT_NXT(a_one_in_flight, in_acc, !in_i.ready, "second transaction taken while busy")
  `BRCC_ASSERT_IMM(a_result_timing, $rose(out_o.valid), $past(in_acc, 15),
                   "result without matching transaction")

endmodule
